// File: rtl/cbt_pkg.sv
// Shared types and constants of the cubic Bezier tessellator.
// Used by cbt_ctrl, cbt_datapath, cubic_bezier_tessellator_unit and its testbench; no dependencies.
package cbt_pkg;

    localparam int DEF_MAX_SEGMENTS = 63;
    localparam int DEF_COORD_BITS   = 20;

    localparam int SEG_W      = 6;              // segment count and vertex index
    localparam int T_W        = 17;             // Q0.16 parameter plus the value one
    localparam logic [T_W-1:0] T_ONE = 17'h10000;
    localparam int DIV_STEPS  = 17;             // quotient bits of 65536 / N
    localparam int DIV_CNT_W  = 5;
    localparam int W_W        = 49;             // Bernstein weight, up to 2^48
    localparam int W_SPLIT    = 24;             // weight split into hi / lo halves

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RUN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic             load;      // capture points, start the divider
        logic             div_step;  // one restoring division step
        logic             run_init;  // clear the parameter accumulator
        logic             issue;     // push one vertex into the pipeline
        logic             last;      // that vertex is the end point
        logic [SEG_W-1:0] idx;
        logic [SEG_W-1:0] seg_n;
    } t_cmd;

    typedef struct packed {
        logic adv;   // pipeline moves this cycle
        logic busy;  // some vertex still in flight
    } t_status;

endpackage

// File: rtl/cbt_ctrl.sv
// Sequencer of the tessellator: setup division, vertex issue, drain.
// Depends on cbt_pkg.
module cbt_ctrl import cbt_pkg::*; #(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [SEG_W-1:0] i_segment_count,
    input  t_status          i_status,
    output t_cmd             o_cmd,
    output logic             o_stall
);

    localparam logic [SEG_W-1:0] MAX_N = SEG_W'(MAX_SEGMENTS);

    t_state               r_state, n_state;
    logic [SEG_W-1:0]     r_n, n_n;
    logic [SEG_W-1:0]     r_i, n_i;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [SEG_W-1:0]     seg_clamped;

    assign seg_clamped = (i_segment_count > MAX_N) ? MAX_N : i_segment_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_n     <= '0;
            r_i     <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_i     <= n_i;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_i     = r_i;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.seg_n = r_n;
        o_cmd.idx   = r_i;
        o_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_n   = seg_clamped;
                    n_i   = '0;
                    n_cnt = '0;
                    n_state = (seg_clamped == '0) ? ST_RUN : ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    o_cmd.run_init = 1'b1;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_status.adv) begin
                    o_cmd.issue = 1'b1;
                    o_cmd.last  = (r_i == r_n);
                    n_i = r_i + 1'b1;
                    if (r_i == r_n) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (!i_status.busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// File: rtl/cbt_datapath.sv
// Datapath: divider for the parameter step, parameter accumulator and the
// Bernstein evaluation pipeline with output register. Depends on cbt_pkg.
module cbt_datapath import cbt_pkg::*; #(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [COORD_BITS-1:0] i_pt [4][2],
    input  logic                  i_stall,
    output t_status               o_status,
    output logic                  o_valid,
    output logic [COORD_BITS-1:0] o_vertex_x,
    output logic [COORD_BITS-1:0] o_vertex_y,
    output logic [SEG_W-1:0]      o_vertex_index,
    output logic                  o_last_vertex
);

    localparam int WH_W  = W_W - W_SPLIT;
    localparam int PH_W  = WH_W + COORD_BITS;
    localparam int PL_W  = W_SPLIT + COORD_BITS;
    localparam int ACC_W = COORD_BITS + 50;
    localparam int RR_W  = ACC_W - W_SPLIT;
    localparam int NSTG  = 6;
    localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << 47;
    localparam logic [COORD_BITS-1:0] MSB  = COORD_BITS'(1) << (COORD_BITS - 1);
    localparam logic [COORD_BITS-1:0] MASK = '1;

    logic [COORD_BITS-1:0] r_pt [4][2];
    logic [COORD_BITS-1:0] bias [4][2];

    logic [SEG_W-1:0] r_rem;
    logic [T_W-1:0]   r_quo;
    logic [T_W-1:0]   r_t;
    logic [SEG_W:0]   r_acc;

    logic             r_v    [NSTG];
    logic [SEG_W-1:0] r_idx  [NSTG];
    logic             r_last [NSTG];

    logic [T_W-1:0]     r_t1, r_u1, r_t2, r_u2;
    logic [2*T_W-1:0]   r_uu, r_ut, r_tt;
    logic [W_W-1:0]     r_m  [4];
    logic [W_W-1:0]     r_w  [4];
    logic [PH_W-1:0]    r_ph [2][4];
    logic [PL_W-1:0]    r_pl [2][4];
    logic [ACC_W-1:0]   r_hs [2];
    logic [ACC_W-1:0]   r_ls [2];

    logic                  r_o_valid;
    logic [COORD_BITS-1:0] r_ox, r_oy;
    logic [SEG_W-1:0]      r_oidx;
    logic                  r_olast;

    logic                  adv;
    logic                  busy;
    logic [SEG_W:0]        div_sh;
    logic                  div_ge;
    logic [SEG_W+1:0]      acc2, twon;
    logic                  wrap;
    logic [COORD_BITS-1:0] res [2];

    assign adv = !r_o_valid || !i_stall;

    always_comb begin
        busy = r_o_valid;
        for (int s = 0; s < NSTG; s++) begin
            busy = busy | r_v[s];
        end
    end

    assign o_status.adv  = adv;
    assign o_status.busy = busy;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            for (int c = 0; c < 2; c++) begin
                bias[k][c] = r_pt[k][c] ^ MSB;
            end
        end
    end

    // restoring division 65536 / N, quotient shifts in at the bottom
    assign div_sh = {r_rem, r_quo[T_W-1]};
    assign div_ge = div_sh >= {1'b0, i_cmd.seg_n};

    // t = round(i * 65536 / N): step by q, remainder 2r against 2N
    assign acc2 = {1'b0, r_acc} + {1'b0, r_rem, 1'b0};
    assign twon = {1'b0, i_cmd.seg_n, 1'b0};
    assign wrap = acc2 >= twon;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pt  <= i_pt;
            r_rem <= '0;
            r_quo <= T_ONE;
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? SEG_W'(div_sh - {1'b0, i_cmd.seg_n}) : div_sh[SEG_W-1:0];
            r_quo <= {r_quo[T_W-2:0], div_ge};
        end
        if (i_cmd.run_init) begin
            r_t   <= '0;
            r_acc <= {1'b0, i_cmd.seg_n};
        end else if (i_cmd.issue) begin
            r_t   <= r_t + r_quo + T_W'(wrap);
            r_acc <= wrap ? (SEG_W+1)'(acc2 - twon) : acc2[SEG_W:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NSTG; s++) begin
                r_v[s] <= 1'b0;
            end
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_cmd.issue;
            for (int s = 1; s < NSTG; s++) begin
                r_v[s] <= r_v[s-1];
            end
            r_o_valid <= r_v[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_idx[0]  <= i_cmd.idx;
            r_last[0] <= i_cmd.last;
            for (int s = 1; s < NSTG; s++) begin
                r_idx[s]  <= r_idx[s-1];
                r_last[s] <= r_last[s-1];
            end
            // stage 1: t and u
            r_t1 <= r_t;
            r_u1 <= T_ONE - r_t;
            // stage 2: squares and cross term
            r_uu <= (2*T_W)'(r_u1) * (2*T_W)'(r_u1);
            r_ut <= (2*T_W)'(r_u1) * (2*T_W)'(r_t1);
            r_tt <= (2*T_W)'(r_t1) * (2*T_W)'(r_t1);
            r_t2 <= r_t1;
            r_u2 <= r_u1;
            // stage 3: cubes
            r_m[0] <= W_W'((3*T_W)'(r_uu) * (3*T_W)'(r_u2));
            r_m[1] <= W_W'((3*T_W)'(r_uu) * (3*T_W)'(r_t2));
            r_m[2] <= W_W'((3*T_W)'(r_ut) * (3*T_W)'(r_t2));
            r_m[3] <= W_W'((3*T_W)'(r_tt) * (3*T_W)'(r_t2));
            // stage 4: binomial factors
            r_w[0] <= r_m[0];
            r_w[1] <= r_m[1] + {r_m[1][W_W-2:0], 1'b0};
            r_w[2] <= r_m[2] + {r_m[2][W_W-2:0], 1'b0};
            r_w[3] <= r_m[3];
            // stage 5: split-weight products per coordinate
            for (int c = 0; c < 2; c++) begin
                for (int k = 0; k < 4; k++) begin
                    r_ph[c][k] <= PH_W'(r_w[k][W_W-1:W_SPLIT]) * PH_W'(bias[k][c]);
                    r_pl[c][k] <= PL_W'(r_w[k][W_SPLIT-1:0]) * PL_W'(bias[k][c]);
                end
            end
            // stage 6: sums
            for (int c = 0; c < 2; c++) begin
                r_hs[c] <= ACC_W'(r_ph[c][0]) + ACC_W'(r_ph[c][1])
                         + ACC_W'(r_ph[c][2]) + ACC_W'(r_ph[c][3]);
                r_ls[c] <= ACC_W'(r_pl[c][0]) + ACC_W'(r_pl[c][1])
                         + ACC_W'(r_pl[c][2]) + ACC_W'(r_pl[c][3]);
            end
            // output: end point on the last vertex
            r_ox    <= r_last[NSTG-1] ? r_pt[3][0] : res[0];
            r_oy    <= r_last[NSTG-1] ? r_pt[3][1] : res[1];
            r_oidx  <= r_idx[NSTG-1];
            r_olast <= r_last[NSTG-1];
        end
    end

    // round half up at 2^-48, saturate, back to two's complement;
    // the high sum is already in units of 2^24
    always_comb begin
        logic [ACC_W-1:0] lr;
        logic [ACC_W-1:0] tot;
        logic [RR_W-1:0]  rr;
        for (int c = 0; c < 2; c++) begin
            lr  = (r_ls[c] + HALF) >> W_SPLIT;
            tot = r_hs[c] + lr;
            rr  = RR_W'(tot >> W_SPLIT);
            if (|rr[RR_W-1:COORD_BITS]) begin
                res[c] = MASK ^ MSB;
            end else begin
                res[c] = rr[COORD_BITS-1:0] ^ MSB;
            end
        end
    end

    assign o_valid        = r_o_valid;
    assign o_vertex_x     = r_ox;
    assign o_vertex_y     = r_oy;
    assign o_vertex_index = r_oidx;
    assign o_last_vertex  = r_olast;

endmodule

// File: rtl/cubic_bezier_tessellator_unit.sv
// Top level of the cubic Bezier tessellator: ports, controller and datapath.
// Depends on cbt_pkg, cbt_ctrl and cbt_datapath.
//
// Takes one curve per input transfer (four control points in signed fixed
// point and a segment count N, clamped to MAX_SEGMENTS) and delivers N+1
// vertex transfers in order; the last one carries the end point unchanged
// and o_last_vertex. Between one curve transfer and the next come the load,
// a bit-serial divider that forms the parameter step 65536/N (skipped when
// N is zero), one vertex issued per cycle while the output does not stall,
// then a seven-register evaluation pipeline that drains, the return to idle,
// and the next transfer. o_stall is high from the load until idle. Output
// stall freezes the pipeline and the issue counter.
module cubic_bezier_tessellator_unit import cbt_pkg::*; #(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    parameter int COORD_BITS   = DEF_COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // curve input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [COORD_BITS-1:0] i_origin_x,
    input  logic [COORD_BITS-1:0] i_origin_y,
    input  logic [COORD_BITS-1:0] i_ctrl1_x,
    input  logic [COORD_BITS-1:0] i_ctrl1_y,
    input  logic [COORD_BITS-1:0] i_ctrl2_x,
    input  logic [COORD_BITS-1:0] i_ctrl2_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    input  logic [SEG_W-1:0]      i_segment_count,
    // vertex output channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [COORD_BITS-1:0] o_vertex_x,
    output logic [COORD_BITS-1:0] o_vertex_y,
    output logic [SEG_W-1:0]      o_vertex_index,
    output logic                  o_last_vertex
);

    t_cmd                  cmd;
    t_status               status;
    logic [COORD_BITS-1:0] pts [4][2];

    // control points in Bernstein order, x then y
    assign pts[0][0] = i_origin_x;
    assign pts[0][1] = i_origin_y;
    assign pts[1][0] = i_ctrl1_x;
    assign pts[1][1] = i_ctrl1_y;
    assign pts[2][0] = i_ctrl2_x;
    assign pts[2][1] = i_ctrl2_y;
    assign pts[3][0] = i_end_x;
    assign pts[3][1] = i_end_y;

    cbt_ctrl #(
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_segment_count(i_segment_count),
        .i_status       (status),
        .o_cmd          (cmd),
        .o_stall        (o_stall)
    );

    cbt_datapath #(
        .COORD_BITS(COORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_pt          (pts),
        .i_stall       (i_stall),
        .o_status      (status),
        .o_valid       (o_valid),
        .o_vertex_x    (o_vertex_x),
        .o_vertex_y    (o_vertex_y),
        .o_vertex_index(o_vertex_index),
        .o_last_vertex (o_last_vertex)
    );

    // a new curve is only taken with the pipeline empty
    a_accept_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |-> !status.busy)
        else $error("curve accepted while vertices in flight");

    // vertices are issued only when the pipeline moves
    a_issue_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.issue |-> status.adv)
        else $error("vertex issued into a stalled pipeline");

    // a transferred vertex that is not the last is followed by the next index
    a_index_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_vertex) ##1 o_valid
        |-> o_vertex_index == $past(o_vertex_index) + 1'b1)
        else $error("vertex index out of sequence");

endmodule

// File: tb/sv/cubic_bezier_tessellator_unit_test.sv
// Testbench of cubic_bezier_tessellator_unit: random and directed curves,
// checked vertex by vertex against a fixed-point Bernstein predictor.
// Depends on cbt_pkg and the RTL of cubic_bezier_tessellator_unit.
module cubic_bezier_tessellator_unit_test;
    import cbt_pkg::*;

    localparam int CW = DEF_COORD_BITS;
    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic [CW-1:0]    x;
        logic [CW-1:0]    y;
        logic [SEG_W-1:0] idx;
        logic             last;
    } t_vertex;

    // Holds the vertices still owed by the block, oldest first.
    class vertex_scoreboard;
        t_vertex pending[$];
        int      mismatches = 0;
        int      curves     = 0;
        int      vertices   = 0;

        // One coordinate: exact Bernstein sum on offset-binary points,
        // round half up at 2^-48, clamp to the top of the biased range.
        function automatic logic [CW-1:0] blend(input logic [71:0] w0, w1, w2, w3,
                                                input logic [CW-1:0] p0, p1, p2, p3);
            logic [71:0] acc;
            logic [71:0] r;
            acc = w0 * {p0[CW-1] ^ 1'b1, p0[CW-2:0]}
                + w1 * {p1[CW-1] ^ 1'b1, p1[CW-2:0]}
                + w2 * {p2[CW-1] ^ 1'b1, p2[CW-2:0]}
                + w3 * {p3[CW-1] ^ 1'b1, p3[CW-2:0]};
            r = (acc + (72'd1 << 47)) >> 48;
            if (r > {CW{1'b1}})
                r = {CW{1'b1}};
            return {r[CW-1] ^ 1'b1, r[CW-2:0]};
        endfunction

        function void note_curve(input logic [CW-1:0] px[4], input logic [CW-1:0] py[4],
                                 input logic [SEG_W-1:0] seg);
            int          n;
            logic [71:0] t, u;
            logic [71:0] w0, w1, w2, w3;
            t_vertex     v;
            n = (seg > DEF_MAX_SEGMENTS) ? DEF_MAX_SEGMENTS : seg;
            curves++;
            for (int i = 0; i < n; i++) begin
                t  = (i * 72'd131072 + n) / (2 * n);
                u  = 72'd65536 - t;
                w0 = u * u * u;
                w1 = 3 * u * u * t;
                w2 = 3 * u * t * t;
                w3 = t * t * t;
                v.x    = blend(w0, w1, w2, w3, px[0], px[1], px[2], px[3]);
                v.y    = blend(w0, w1, w2, w3, py[0], py[1], py[2], py[3]);
                v.idx  = i[SEG_W-1:0];
                v.last = 1'b0;
                pending.push_back(v);
            end
            v.x    = px[3];
            v.y    = py[3];
            v.idx  = n[SEG_W-1:0];
            v.last = 1'b1;
            pending.push_back(v);
        endfunction

        function void check_vertex(input t_vertex got);
            t_vertex exp_v;
            vertices++;
            if (pending.size() == 0) begin
                $error("vertex with nothing pending: x=%0h y=%0h idx=%0d",
                       got.x, got.y, got.idx);
                mismatches++;
                return;
            end
            exp_v = pending.pop_front();
            if (got.x !== exp_v.x) begin
                $error("vertex_x expected %0h got %0h", exp_v.x, got.x);
                mismatches++;
            end
            if (got.y !== exp_v.y) begin
                $error("vertex_y expected %0h got %0h", exp_v.y, got.y);
                mismatches++;
            end
            if (got.idx !== exp_v.idx) begin
                $error("vertex_index expected %0d got %0d", exp_v.idx, got.idx);
                mismatches++;
            end
            if (got.last !== exp_v.last) begin
                $error("last_vertex expected %0b got %0b", exp_v.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic [CW-1:0]    i_origin_x = '0, i_origin_y = '0;
    logic [CW-1:0]    i_ctrl1_x = '0, i_ctrl1_y = '0;
    logic [CW-1:0]    i_ctrl2_x = '0, i_ctrl2_y = '0;
    logic [CW-1:0]    i_end_x = '0, i_end_y = '0;
    logic [SEG_W-1:0] i_segment_count = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [CW-1:0]    o_vertex_x, o_vertex_y;
    logic [SEG_W-1:0] o_vertex_index;
    logic             o_last_vertex;

    vertex_scoreboard sb = new();

    cubic_bezier_tessellator_unit dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Run-away guard: far beyond the slowest legal run.
    initial begin
        #30000000;
        $display("TB_ERROR");
        $finish;
    end

    // Output side: stall pattern switches between none, light and heavy
    // phases of random length so stalls land on every pipeline stage.
    int stall_mode = 0;
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(10, 150);
        end
        stall_left--;
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 99) < 25);
            default: i_stall <= ($urandom_range(0, 99) < 70);
        endcase
    end

    // Accepted vertices go to the scoreboard at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_vertex({o_vertex_x, o_vertex_y, o_vertex_index, o_last_vertex});
    end

    // Sender bursts: number of curves left before the next gap.
    int burst_left = 0;

    // Drive one curve and hold it until the transfer happens; then maybe
    // open an idle gap. Called right after a falling edge.
    task automatic send_curve(input logic [CW-1:0] px[4], input logic [CW-1:0] py[4],
                              input logic [SEG_W-1:0] seg);
        int gap;
        i_origin_x = px[0]; i_origin_y = py[0];
        i_ctrl1_x  = px[1]; i_ctrl1_y  = py[1];
        i_ctrl2_x  = px[2]; i_ctrl2_y  = py[2];
        i_end_x    = px[3]; i_end_y    = py[3];
        i_segment_count = seg;
        i_valid = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_stall)
                break;
        end
        sb.note_curve(px, py, seg);
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                i_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
    endtask

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return CMAX;
            1: return CMIN;
            2: return CW'($urandom_range(0, 255) - 128);
            default: return CW'($urandom);
        endcase
    endfunction

    initial begin
        logic [CW-1:0]    px[4], py[4];
        logic [SEG_W-1:0] seg;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: extremes of every coordinate and count, and zero segments.
        for (int d = 0; d < 20; d++) begin
            for (int k = 0; k < 4; k++) begin
                case (d % 5)
                    0: begin px[k] = CMAX; py[k] = CMAX; end
                    1: begin px[k] = CMIN; py[k] = CMIN; end
                    2: begin px[k] = k[0] ? CMAX : CMIN; py[k] = k[0] ? CMIN : CMAX; end
                    3: begin px[k] = '0; py[k] = {CW{1'b1}}; end
                    default: begin px[k] = rand_coord(); py[k] = rand_coord(); end
                endcase
            end
            case (d / 5)
                0: seg = '0;
                1: seg = SEG_W'(63);
                2: seg = SEG_W'(1);
                default: seg = (d % 2) ? SEG_W'(2) : SEG_W'(3);
            endcase
            send_curve(px, py, seg);
        end

        // Random: mostly short curves, a few with zero segments or any count up to 63.
        for (int r = 0; r < 360; r++) begin
            for (int k = 0; k < 4; k++) begin
                px[k] = rand_coord();
                py[k] = rand_coord();
            end
            case ($urandom_range(0, 9))
                0: seg = SEG_W'($urandom);
                1: seg = '0;
                default: seg = SEG_W'($urandom_range(1, 16));
            endcase
            send_curve(px, py, seg);
        end
        i_valid = 1'b0;

        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("Tessellated %0d curves into %0d vertices under random input gaps",
                 sb.curves, sb.vertices);
        $display("and output stalls; %0d field mismatches.", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: cubic_bezier_tessellator_unit.f
rtl/cbt_pkg.sv
rtl/cbt_ctrl.sv
rtl/cbt_datapath.sv
rtl/cubic_bezier_tessellator_unit.sv
tb/sv/cubic_bezier_tessellator_unit_test.sv
